### rtl/core/wdsup_pkg.sv
// Shared types and constants for the multi-task watchdog supervisor.
// No dependencies; used by wdsup_core, wdsup_checker and the top level.
package wdsup_pkg;

  typedef enum logic [2:0] {
    KIND_REGISTER = 3'd0,
    KIND_CHECKIN  = 3'd1,
    KIND_EVALUATE = 3'd2,
    KIND_ENABLE   = 3'd3,
    KIND_DISABLE  = 3'd4,
    KIND_FAULT    = 3'd5
  } kind_t;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned ADDR_W  = 3;

  // word index of each config register (paddr[2])
  localparam logic REG_DEADLINE = 1'b0;
  localparam logic REG_GRACE    = 1'b1;

  localparam logic [TICK_W-1:0] DEADLINE_RST = 32'd327680;
  localparam logic [TICK_W-1:0] GRACE_RST    = 32'd983040;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        task_index;
    logic [TICK_W-1:0] now_ticks;
    logic [CODE_W-1:0] fault_code;
  } cmd_t;

  typedef struct packed {
    logic              restart_pulse;
    logic [CODE_W-1:0] stall_code;
    logic [CODE_W-1:0] held_diagnostic;
    logic              supervisor_enabled;
  } res_t;

endpackage

### rtl/core/wdsup_core.sv
// Supervisor state and combinational event evaluation over all tasks in parallel.
// Depends on wdsup_pkg.
module wdsup_core #(
  parameter int unsigned TASK_COUNT = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  wdsup_pkg::cmd_t                cmd,
  input  logic [wdsup_pkg::TICK_W-1:0]   deadline,
  input  logic [wdsup_pkg::TICK_W-1:0]   grace,
  output wdsup_pkg::res_t                res
);

  logic                           armed_r, armed_nxt;
  logic [wdsup_pkg::TICK_W-1:0]   armed_time_r;
  logic [wdsup_pkg::TICK_W-1:0]   last_r [TASK_COUNT];
  logic [TASK_COUNT-1:0]          mon_r, mon_nxt;
  logic [wdsup_pkg::CODE_W-1:0]   diag_r, diag_nxt;

  logic                           idx_ok;
  logic [TASK_COUNT-1:0]          hit;
  logic [TASK_COUNT-1:0]          late;
  logic                           is_checkin;
  logic                           do_eval;
  logic                           in_grace;
  logic                           multi;
  logic [wdsup_pkg::CODE_W-1:0]   first;
  logic [wdsup_pkg::CODE_W-1:0]   code;
  logic [wdsup_pkg::CODE_W-1:0]   stall_code;
  logic [wdsup_pkg::TICK_W-1:0]   since_arm;

  assign idx_ok     = cmd.task_index < wdsup_pkg::CODE_W'(TASK_COUNT);
  assign is_checkin = cmd.kind == wdsup_pkg::KIND_CHECKIN;
  assign do_eval    = armed_r && ((cmd.kind == wdsup_pkg::KIND_EVALUATE) ||
                                  (is_checkin && idx_ok));
  assign since_arm  = cmd.now_ticks - armed_time_r;
  assign in_grace   = since_arm < grace;

  // the checking-in task has elapsed time zero, never late
  always_comb begin
    for (int t = 0; t < TASK_COUNT; t++) begin
      hit[t]  = cmd.task_index == 4'(t);
      late[t] = mon_r[t] && !(is_checkin && hit[t]) &&
                ((cmd.now_ticks - last_r[t]) > deadline);
    end
  end

  always_comb begin
    first = '0;
    for (int t = TASK_COUNT - 1; t >= 0; t--) begin
      if (late[t]) begin
        first = wdsup_pkg::CODE_W'(t + 1);
      end
    end
  end

  assign multi      = |(late & (late - TASK_COUNT'(1)));
  assign code       = multi ? wdsup_pkg::CODE_W'(TASK_COUNT + 1) : first;
  assign stall_code = (do_eval && !in_grace) ? code : '0;

  always_comb begin
    armed_nxt = armed_r;
    mon_nxt   = mon_r;
    diag_nxt  = diag_r;
    case (cmd.kind)
      wdsup_pkg::KIND_REGISTER: begin
        if (idx_ok) begin
          mon_nxt = mon_r | hit;
        end
      end
      wdsup_pkg::KIND_ENABLE: begin
        armed_nxt = 1'b1;
      end
      wdsup_pkg::KIND_DISABLE: begin
        if (armed_r) begin
          armed_nxt = 1'b0;
          mon_nxt   = '0;
        end
      end
      wdsup_pkg::KIND_FAULT: begin
        if (cmd.fault_code != '0 && diag_r == '0) begin
          diag_nxt = cmd.fault_code;
        end
      end
      default: begin
      end
    endcase
    if (stall_code != '0 && diag_r == '0) begin
      diag_nxt = stall_code;
    end
  end

  assign res.restart_pulse      = do_eval && (in_grace || code == '0);
  assign res.stall_code         = stall_code;
  assign res.held_diagnostic    = diag_nxt;
  assign res.supervisor_enabled = armed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      mon_r   <= '0;
      diag_r  <= '0;
    end else if (step) begin
      armed_r <= armed_nxt;
      mon_r   <= mon_nxt;
      diag_r  <= diag_nxt;
    end
  end

  // timestamps are only read after an enable has written them all
  always_ff @(posedge clk) begin
    if (step) begin
      if (cmd.kind == wdsup_pkg::KIND_ENABLE) begin
        armed_time_r <= cmd.now_ticks;
      end
      for (int t = 0; t < TASK_COUNT; t++) begin
        if (cmd.kind == wdsup_pkg::KIND_ENABLE) begin
          last_r[t] <= cmd.now_ticks;
        end else if (hit[t] && idx_ok &&
                     (cmd.kind == wdsup_pkg::KIND_REGISTER || (is_checkin && armed_r))) begin
          last_r[t] <= cmd.now_ticks;
        end
      end
    end
  end

endmodule

### rtl/core/multi_task_watchdog_supervisor_unit.sv
// Top level: event and result channels, APB config registers, pipeline registers.
// Depends on wdsup_pkg and wdsup_core.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  kind, task_index, now_ticks, fault_code
//   out_     output     out_valid/out_stall restart_pulse, stall_code,
//                                           held_diagnostic, supervisor_enabled
//   cfg      APB        psel/penable/pready checkin deadline (0x0), startup grace (0x4)
//
// One beat per cycle while out_stall does not hold the pipeline: input register, then
// evaluation of all tasks in parallel into the result register.
// Synchronous active-low reset clears the pipeline valids, armed bit,
// monitored flags and diagnostic latch; config registers return to defaults.
// out_stall holds the result register; in_stall rises only when both stages are full.
module multi_task_watchdog_supervisor_unit #(
  parameter int unsigned TASK_COUNT = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_kind,
  input  logic [3:0]                         in_task_index,
  input  logic [wdsup_pkg::TICK_W-1:0]       in_now_ticks,
  input  logic [wdsup_pkg::CODE_W-1:0]       in_fault_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_restart_pulse,
  output logic [wdsup_pkg::CODE_W-1:0]       out_stall_code,
  output logic [wdsup_pkg::CODE_W-1:0]       out_held_diagnostic,
  output logic                               out_supervisor_enabled,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wdsup_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [wdsup_pkg::TICK_W-1:0] deadline_r;
  logic [wdsup_pkg::TICK_W-1:0] grace_r;
  logic                         cfg_wr;

  logic                         in_v_r;
  wdsup_pkg::cmd_t              cmd_r;
  logic                         out_v_r;
  wdsup_pkg::res_t              res_r;
  wdsup_pkg::res_t              res;
  logic                         advance;
  logic                         in_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == wdsup_pkg::REG_GRACE) ? grace_r : deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= wdsup_pkg::DEADLINE_RST;
      grace_r    <= wdsup_pkg::GRACE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == wdsup_pkg::REG_GRACE) begin
        grace_r <= pwdata;
      end else begin
        deadline_r <= pwdata;
      end
    end
  end

  assign advance  = !out_v_r || !out_stall;
  assign in_stall = in_v_r && !advance;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_v_r || advance) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      cmd_r.kind       <= in_kind;
      cmd_r.task_index <= in_task_index;
      cmd_r.now_ticks  <= in_now_ticks;
      cmd_r.fault_code <= in_fault_code;
    end
    if (advance && in_v_r) begin
      res_r <= res;
    end
  end

  wdsup_core #(
    .TASK_COUNT(TASK_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance && in_v_r),
    .cmd      (cmd_r),
    .deadline (deadline_r),
    .grace    (grace_r),
    .res      (res)
  );

  assign out_valid              = out_v_r;
  assign out_restart_pulse      = res_r.restart_pulse;
  assign out_stall_code         = res_r.stall_code;
  assign out_held_diagnostic    = res_r.held_diagnostic;
  assign out_supervisor_enabled = res_r.supervisor_enabled;

endmodule

### rtl/core/wdsup_checker.sv
// Port-level checks on the supervisor's result channel, bound to the top level.
// Depends on wdsup_pkg and multi_task_watchdog_supervisor_unit.
module wdsup_checker #(
  parameter int unsigned TASK_COUNT = 5
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_restart_pulse,
  input logic [wdsup_pkg::CODE_W-1:0] out_stall_code,
  input logic [wdsup_pkg::CODE_W-1:0] out_held_diagnostic,
  input logic                         out_supervisor_enabled
);

  a_pet_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_restart_pulse |-> out_stall_code == '0)
    else $error("pet beat carries a stall code");

  a_stall_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall_code != '0 |-> out_held_diagnostic != '0 &&
                                          !out_restart_pulse)
    else $error("stall beat without latched diagnostic");

  a_pet_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_restart_pulse || out_stall_code != '0) |-> out_supervisor_enabled)
    else $error("evaluation result while disarmed");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stall_code <= wdsup_pkg::CODE_W'(TASK_COUNT + 1))
    else $error("stall code out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stall_code) &&
                               $stable(out_held_diagnostic) && $stable(out_restart_pulse))
    else $error("stalled result beat changed");

endmodule

bind multi_task_watchdog_supervisor_unit wdsup_checker #(
  .TASK_COUNT(TASK_COUNT)
) u_wdsup_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_restart_pulse      (out_restart_pulse),
  .out_stall_code         (out_stall_code),
  .out_held_diagnostic    (out_held_diagnostic),
  .out_supervisor_enabled (out_supervisor_enabled)
);
